>>> hdl/sap_hdr_pkg.sv
// ----------------------------------------------------------------------------
// sap_hdr_pkg
// Shared constants, codes and types of the SAP header parser.
// ----------------------------------------------------------------------------
package sap_hdr_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 2);
  localparam int CALC_W = (POS_W > 12) ? POS_W : 12;

  localparam int V4_BASE    = 8;
  localparam int V6_BASE    = 20;
  localparam int MIN_LEN    = 12;
  localparam int MIN_LEN_V6 = 24;

  localparam int FLAG_V6  = 4;
  localparam int FLAG_DEL = 2;
  localparam int FLAG_ENC = 1;
  localparam int FLAG_CMP = 0;
  localparam logic [2:0] SAP_VERSION = 3'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_ENCRYPTED = 3'd3,
    ST_COMPRESS  = 3'd4,
    ST_AUTH      = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

  // packet state as seen after the current byte
  typedef struct packed {
    logic [POS_W-1:0] idx;
    logic             overflow;
    logic [7:0]       flags;
    logic [7:0]       auth_size;
    logic [15:0]      msg_id;
    logic [63:0]      addr_hi;
    logic [63:0]      addr_lo;
    logic             pfx_mismatch;
    logic             term_found;
    logic [POS_W-1:0] term_pos;
  } pkt_view_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h76;
      2'd1:    c = 8'h3D;
      2'd2:    c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/sap_hdr_in_if.sv
// ----------------------------------------------------------------------------
// sap_hdr_in_if
// Byte stream channel into the SAP header parser.
// ----------------------------------------------------------------------------
interface sap_hdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/sap_hdr_out_if.sv
// ----------------------------------------------------------------------------
// sap_hdr_out_if
// Packet summary channel out of the SAP header parser.
// ----------------------------------------------------------------------------
interface sap_hdr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_deletion;
  logic        source_is_ipv6;
  logic [15:0] msg_hash;
  logic [63:0] source_addr_high;
  logic [63:0] source_addr_low;
  logic [10:0] type_length;
  logic [11:0] payload_offset;
  logic [11:0] payload_length;

  modport source (output valid, output status, output is_deletion, output source_is_ipv6,
                  output msg_hash, output source_addr_high, output source_addr_low,
                  output type_length, output payload_offset, output payload_length,
                  input ready);
  modport sink   (input valid, input status, input is_deletion, input source_is_ipv6,
                  input msg_hash, input source_addr_high, input source_addr_low,
                  input type_length, input payload_offset, input payload_length,
                  output ready);
endinterface

>>> hdl/sap_hdr_capture.sv
// ----------------------------------------------------------------------------
// sap_hdr_capture
// Per-byte header field capture, prefix check and terminator search.
// ----------------------------------------------------------------------------
module sap_hdr_capture (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output sap_hdr_pkg::pkt_view_t view
);
  import sap_hdr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [7:0]       auth_r, auth_nxt;
  logic [15:0]      msg_id_r, msg_id_nxt;
  logic [63:0]      addr_hi_r, addr_hi_nxt;
  logic [63:0]      addr_lo_r, addr_lo_nxt;
  logic             pfx_mis_r, pfx_mis_nxt;
  logic             term_found_r, term_found_nxt;
  logic [POS_W-1:0] term_pos_r, term_pos_nxt;

  logic             overflow;
  logic [POS_W-1:0] base;
  logic [POS_W-1:0] off;

  always_comb begin
    overflow       = pos_r >= POS_W'(MAX_PACKET_BYTES);
    base           = ((pos_r != '0) && flags_r[FLAG_V6]) ? POS_W'(V6_BASE) : POS_W'(V4_BASE);
    off            = pos_r - base;
    flags_nxt      = flags_r;
    auth_nxt       = auth_r;
    msg_id_nxt     = msg_id_r;
    addr_hi_nxt    = addr_hi_r;
    addr_lo_nxt    = addr_lo_r;
    pfx_mis_nxt    = pfx_mis_r;
    term_found_nxt = term_found_r;
    term_pos_nxt   = term_pos_r;
    if (!overflow) begin
      priority if (pos_r == POS_W'(0)) begin
        flags_nxt = data_byte;
      end else if (pos_r == POS_W'(1)) begin
        auth_nxt = data_byte;
      end else if (pos_r <= POS_W'(3)) begin
        msg_id_nxt = {msg_id_r[7:0], data_byte};
      end else if (pos_r <= POS_W'(11)) begin
        addr_hi_nxt = {addr_hi_r[55:0], data_byte};
      end else if (pos_r <= POS_W'(19)) begin
        addr_lo_nxt = {addr_lo_r[55:0], data_byte};
      end else begin
        // hold the header fields
      end
      if (pos_r >= base) begin
        if ((off < POS_W'(3)) && (data_byte != prefix_char(off[1:0]))) begin
          pfx_mis_nxt = 1'b1;
        end
        if ((data_byte == 8'h00) && !term_found_r) begin
          term_found_nxt = 1'b1;
          term_pos_nxt   = pos_r;
        end
      end
    end
    pos_nxt = (pos_r <= POS_W'(MAX_PACKET_BYTES)) ? pos_r + POS_W'(1) : pos_r;
  end

  always_comb begin
    view.idx          = pos_r;
    view.overflow     = overflow;
    view.flags        = flags_nxt;
    view.auth_size    = auth_nxt;
    view.msg_id       = msg_id_nxt;
    view.addr_hi      = addr_hi_nxt;
    view.addr_lo      = addr_lo_nxt;
    view.pfx_mismatch = pfx_mis_nxt;
    view.term_found   = term_found_nxt;
    view.term_pos     = term_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      pos_r        <= '0;
      flags_r      <= '0;
      auth_r       <= '0;
      msg_id_r     <= '0;
      addr_hi_r    <= '0;
      addr_lo_r    <= '0;
      pfx_mis_r    <= 1'b0;
      term_found_r <= 1'b0;
      term_pos_r   <= '0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      flags_r      <= flags_nxt;
      auth_r       <= auth_nxt;
      msg_id_r     <= msg_id_nxt;
      addr_hi_r    <= addr_hi_nxt;
      addr_lo_r    <= addr_lo_nxt;
      pfx_mis_r    <= pfx_mis_nxt;
      term_found_r <= term_found_nxt;
      term_pos_r   <= term_pos_nxt;
    end
  end

endmodule

>>> hdl/sap_header_parser.sv
// ----------------------------------------------------------------------------
// sap_header_parser
// Parses a SAP packet byte by byte and emits one summary per packet.
//
//   channel  | dir | transaction
//   in_ch    | in  | one packet byte, last_byte marks the end of the packet
//   out_ch   | out | one header summary per packet
//
// One byte per cycle while in_ch.ready is high; the summary is registered and shows up on
// out_ch the cycle after the last byte is taken.
// in_ch.ready drops only for a last byte while a summary is held and
// out_ch.ready is low; bytes inside a packet keep flowing.
// rst_n (synchronous) clears the packet state and the held summary.
// ----------------------------------------------------------------------------
module sap_header_parser (
  input logic         clk,
  input logic         rst_n,
  sap_hdr_in_if.sink  in_ch,
  sap_hdr_out_if.source out_ch
);
  import sap_hdr_pkg::*;

  pkt_view_t        view;
  logic             accept;
  logic             v6;
  logic [CALC_W-1:0] len;
  logic [CALC_W-1:0] base;
  logic [CALC_W-1:0] start;
  logic [CALC_W-1:0] tlen;
  logic [CALC_W-1:0] plen;
  status_t          status;

  logic        out_valid_r;
  status_t     status_r;
  logic        del_r;
  logic        v6_r;
  logic [15:0] msg_id_r;
  logic [63:0] addr_hi_r;
  logic [63:0] addr_lo_r;
  logic [10:0] tlen_r;
  logic [11:0] poff_r;
  logic [11:0] plen_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready || !in_ch.last_byte;
  assign accept      = in_ch.valid && in_ch.ready;

  sap_hdr_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .view      (view)
  );

  always_comb begin
    v6    = view.flags[FLAG_V6];
    len   = CALC_W'(view.idx) + CALC_W'(1);
    base  = v6 ? CALC_W'(V6_BASE) : CALC_W'(V4_BASE);
    start = base;
    tlen  = '0;
    if (view.pfx_mismatch && view.term_found) begin
      tlen  = CALC_W'(view.term_pos) - base;
      start = CALC_W'(view.term_pos) + CALC_W'(1);
    end
    plen = len - start;
    priority if (view.overflow) begin
      status = ST_TOO_LONG;
    end else if (len < CALC_W'(MIN_LEN)) begin
      status = ST_SHORT;
    end else if (view.flags[7:5] != SAP_VERSION) begin
      status = ST_BAD_VER;
    end else if (v6 && (len < CALC_W'(MIN_LEN_V6))) begin
      status = ST_SHORT;
    end else if (view.flags[FLAG_ENC]) begin
      status = ST_ENCRYPTED;
    end else if (view.flags[FLAG_CMP]) begin
      status = ST_COMPRESS;
    end else if (view.auth_size != 8'h00) begin
      status = ST_AUTH;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_byte) begin
      status_r <= status;
      if (status == ST_OK) begin
        del_r     <= view.flags[FLAG_DEL];
        v6_r      <= v6;
        msg_id_r  <= view.msg_id;
        addr_hi_r <= v6 ? view.addr_hi : 64'h0;
        addr_lo_r <= v6 ? view.addr_lo : {32'h0, view.addr_hi[63:32]};
        tlen_r    <= tlen[10:0];
        poff_r    <= start[11:0];
        plen_r    <= plen[11:0];
      end else begin
        del_r     <= 1'b0;
        v6_r      <= 1'b0;
        msg_id_r  <= '0;
        addr_hi_r <= '0;
        addr_lo_r <= '0;
        tlen_r    <= '0;
        poff_r    <= '0;
        plen_r    <= '0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.is_deletion      = del_r;
  assign out_ch.source_is_ipv6   = v6_r;
  assign out_ch.msg_hash         = msg_id_r;
  assign out_ch.source_addr_high = addr_hi_r;
  assign out_ch.source_addr_low  = addr_lo_r;
  assign out_ch.type_length      = tlen_r;
  assign out_ch.payload_offset   = poff_r;
  assign out_ch.payload_length   = plen_r;

  a_summary_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_byte |=> out_valid_r)
    else $error("no summary after last byte");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with no summary held");

  a_mid_packet_keeps_summary: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.last_byte && out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("held summary lost on mid-packet byte");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> (msg_id_r == 16'h0) && !del_r && !v6_r
      && (addr_lo_r == 64'h0) && (plen_r == 12'h0))
    else $error("error summary carries field data");

  a_v4_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !v6_r |-> (addr_hi_r == 64'h0))
    else $error("IPv4 summary with upper address bits");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream testbench for the SAP header parser. Packets are sent one byte
// per transaction with random bursts and gaps while the summary side stalls on
// its own pattern. A parse model tracks every accepted byte and queues the
// summary each packet should produce; every summary transaction is compared
// field by field against the oldest queued one. Directed packets cover the
// header checks in priority order, payload type extraction and the length
// limits, then random well-formed, broken and noise packets follow.
// ----------------------------------------------------------------------------
module tb_top;
  import sap_hdr_pkg::*;

  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam logic [23:0] SDP_PREFIX   = "v=0";
  localparam logic [15:0] RX_PATTERN   = 16'b1101_0110_0111_0010;

  typedef struct packed {
    status_t     status;
    logic        is_deletion;
    logic        source_is_ipv6;
    logic [15:0] msg_hash;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [10:0] type_length;
    logic [11:0] payload_offset;
    logic [11:0] payload_length;
  } sap_summary_t;

  logic clk;
  logic rst_n;

  sap_hdr_in_if  in_ch();
  sap_hdr_out_if out_ch();

  sap_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sap_summary_t summaries_due[$];
  logic [7:0]   pkt_bytes[$];

  int          pkt_pos;
  logic [7:0]  pkt_flags;
  logic [7:0]  pkt_auth;
  logic [15:0] pkt_msg_id;
  logic [63:0] pkt_addr_hi;
  logic [63:0] pkt_addr_lo;
  bit          pkt_pfx_bad;
  bit          pkt_term_found;
  int          pkt_term_pos;

  int       mismatches;
  int       cycle_count;
  int       sent_bytes;
  int       burst_left;
  bit       gaps_on;
  int       rx_mode;
  bit [3:0] rx_phase;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sap_header_parser: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_phase <= rx_phase + 4'd1;
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= RX_PATTERN[rx_phase];
      2: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void clear_parse_state();
    pkt_pos        = 0;
    pkt_flags      = '0;
    pkt_auth       = '0;
    pkt_msg_id     = '0;
    pkt_addr_hi    = '0;
    pkt_addr_lo    = '0;
    pkt_pfx_bad    = 1'b0;
    pkt_term_found = 1'b0;
    pkt_term_pos   = 0;
  endfunction

  function automatic void track_sap_byte(input logic [7:0] b, input logic last);
    int           idx;
    int           base;
    int           k;
    int           len;
    int           start;
    bit           overflow;
    bit           v6;
    status_t      st;
    sap_summary_t s;
    idx = pkt_pos;
    overflow = (idx >= MAX_PACKET_BYTES);
    if (!overflow) begin
      base = (idx > 0 && pkt_flags[FLAG_V6]) ? V6_BASE : V4_BASE;
      if (idx == 0) begin
        pkt_flags = b;
      end else if (idx == 1) begin
        pkt_auth = b;
      end else if (idx <= 3) begin
        pkt_msg_id = {pkt_msg_id[7:0], b};
      end else if (idx <= 11) begin
        pkt_addr_hi = {pkt_addr_hi[55:0], b};
      end else if (idx <= 19) begin
        pkt_addr_lo = {pkt_addr_lo[55:0], b};
      end
      if (idx >= base) begin
        k = idx - base;
        if (k < 3 && b != SDP_PREFIX[8*(2-k) +: 8]) pkt_pfx_bad = 1'b1;
        if (b == 8'h00 && !pkt_term_found) begin
          pkt_term_found = 1'b1;
          pkt_term_pos   = idx;
        end
      end
    end
    if (pkt_pos <= MAX_PACKET_BYTES) pkt_pos++;
    if (!last) return;

    len = idx + 1;
    v6  = pkt_flags[FLAG_V6];
    s   = '0;
    if (overflow) st = ST_TOO_LONG;
    else if (len < MIN_LEN) st = ST_SHORT;
    else if (pkt_flags[7:5] != SAP_VERSION) st = ST_BAD_VER;
    else if (v6 && len < MIN_LEN_V6) st = ST_SHORT;
    else if (pkt_flags[FLAG_ENC]) st = ST_ENCRYPTED;
    else if (pkt_flags[FLAG_CMP]) st = ST_COMPRESS;
    else if (pkt_auth != 8'h00) st = ST_AUTH;
    else st = ST_OK;
    s.status = st;
    if (st == ST_OK) begin
      start = v6 ? V6_BASE : V4_BASE;
      s.is_deletion    = pkt_flags[FLAG_DEL];
      s.source_is_ipv6 = v6;
      s.msg_hash       = pkt_msg_id;
      if (v6) begin
        s.source_addr_high = pkt_addr_hi;
        s.source_addr_low  = pkt_addr_lo;
      end else begin
        s.source_addr_low = {32'h0, pkt_addr_hi[63:32]};
      end
      if (pkt_pfx_bad && pkt_term_found) begin
        s.type_length = 11'(pkt_term_pos - start);
        start = pkt_term_pos + 1;
      end
      s.payload_offset = 12'(start);
      s.payload_length = 12'(len - start);
    end
    summaries_due.push_back(s);
    clear_parse_state();
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin : check_summaries
    sap_summary_t due;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (summaries_due.size() == 0) begin
        mismatches++;
        $display("%0t unexpected summary: expected none, actual status %0d",
                 $time, out_ch.status);
      end else begin
        due = summaries_due.pop_front();
        check_field("status", 64'(due.status), 64'(out_ch.status));
        check_field("is_deletion", 64'(due.is_deletion), 64'(out_ch.is_deletion));
        check_field("source_is_ipv6", 64'(due.source_is_ipv6), 64'(out_ch.source_is_ipv6));
        check_field("msg_hash", 64'(due.msg_hash), 64'(out_ch.msg_hash));
        check_field("source_addr_high", due.source_addr_high, out_ch.source_addr_high);
        check_field("source_addr_low", due.source_addr_low, out_ch.source_addr_low);
        check_field("type_length", 64'(due.type_length), 64'(out_ch.type_length));
        check_field("payload_offset", 64'(due.payload_offset), 64'(out_ch.payload_offset));
        check_field("payload_length", 64'(due.payload_length), 64'(out_ch.payload_length));
      end
    end
  end

  function automatic logic [7:0] sap_flags(input logic [2:0] ver, input bit v6, input bit del,
                                           input bit enc, input bit cmp);
    logic [7:0] f;
    f = '0;
    f[7:5]      = ver;
    f[FLAG_V6]  = v6;
    f[FLAG_DEL] = del;
    f[FLAG_ENC] = enc;
    f[FLAG_CMP] = cmp;
    return f;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    track_sap_byte(b, last);
    sent_bytes++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (summaries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // fill < 0: random id and address bytes
  function automatic void start_packet(input logic [7:0] flags, input logic [7:0] auth,
                                       input int fill);
    pkt_bytes.push_back(flags);
    pkt_bytes.push_back(auth);
    repeat (flags[FLAG_V6] ? 18 : 6)
      pkt_bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endfunction

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endfunction

  // zero_odds < 0: never zero, 0: uniform, n > 0: zero one time in n
  function automatic void append_random(input int n, input int zero_odds);
    repeat (n) begin
      if (zero_odds < 0) pkt_bytes.push_back(8'($urandom_range(1, 255)));
      else if (zero_odds == 0) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      else if ($urandom_range(0, zero_odds - 1) == 0) pkt_bytes.push_back(8'h00);
      else pkt_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void append_payload(input int kind);
    case (kind)
      0: begin
        append_text("v=0");
        append_random($urandom_range(0, 20), 0);
      end
      1: begin
        repeat ($urandom_range(0, 12)) pkt_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        pkt_bytes.push_back(8'h00);
        append_text("v=0\r\n");
        append_random($urandom_range(0, 12), 0);
      end
      2: append_random($urandom_range(0, 30), 8);
      default: begin
        append_text("v=");
        append_random($urandom_range(0, 10), 4);
      end
    endcase
  endfunction

  task automatic test_header_checks();
    gaps_on = 1'b0;
    rx_mode <= 0;
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    void'(pkt_bytes.pop_back());
    while (pkt_bytes.size() > 1) void'(pkt_bytes.pop_back());
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    append_random(4, -1);
    void'(pkt_bytes.pop_back());
    send_packet();
    start_packet(8'h00, 8'h00, 0);
    append_random(4, 0);
    send_packet();
    start_packet(8'hFF, 8'hFF, 8'hFF);
    append_random(4, 0);
    while (pkt_bytes.size() > MIN_LEN) void'(pkt_bytes.pop_back());
    send_packet();
    start_packet(sap_flags(3'd2, 0, 0, 0, 0), 8'h00, -1);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 1, 0, 1, 0), 8'h00, -1);
    append_text("v=");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 1, 1, 1), 8'h00, -1);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 1), 8'h00, -1);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 1, 0, 0, 0), 8'hFF, -1);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h01, -1);
    append_text("v=0\n");
    send_packet();
    wait_drain();
  endtask

  task automatic test_payload_type();
    gaps_on = 1'b1;
    rx_mode <= 1;
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, 8'hFF);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 1, 0, 0), 8'h00, -1);
    append_text("application/sdp");
    pkt_bytes.push_back(8'h00);
    append_text("v=0\r\no=-\r\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 1, 1, 0, 0), 8'h00, 8'h00);
    append_text("sdp");
    pkt_bytes.push_back(8'h00);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 1, 0, 0, 0), 8'h00, 8'hFF);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    append_text("x=0abcdef");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    append_text("v=0ab");
    pkt_bytes.push_back(8'h00);
    append_text("cd");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    pkt_bytes.push_back(8'h00);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    append_text("v");
    pkt_bytes.push_back(8'h00);
    append_text("=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    append_text("v=1type");
    pkt_bytes.push_back(8'h00);
    send_packet();
    wait_drain();
  endtask

  task automatic test_length_limits();
    gaps_on = 1'b1;
    rx_mode <= 2;
    start_packet(sap_flags(SAP_VERSION, 1, 0, 0, 0), 8'h00, -1);
    append_text("v=0\n");
    send_packet();
    start_packet(sap_flags(SAP_VERSION, 0, 0, 0, 0), 8'h00, -1);
    append_text("v=0");
    append_random(MAX_PACKET_BYTES - 10, 0);
    send_packet();
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int         packets;
    int         kind;
    logic [7:0] flags;
    logic [7:0] auth;
    packets   = 0;
    sent_bytes = 0;
    while (sent_bytes < 1000 || packets < 60) begin
      if (packets % 16 == 0) begin
        rx_mode <= $urandom_range(0, 3);
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      if (packets % 25 == 24) wait_drain();
      kind = $urandom_range(0, 39);
      if (kind < 6) begin
        append_random($urandom_range(1, 40), 0);
      end else begin
        flags = sap_flags(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : SAP_VERSION,
                          $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        flags[3] = $urandom_range(0, 1);
        auth = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        start_packet(flags, auth, -1);
        append_payload($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
          while (pkt_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(pkt_bytes.pop_back());
      end
      send_packet();
      packets++;
    end
    wait_drain();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    rx_mode         <= 0;
    mismatches = 0;
    sent_bytes = 0;
    burst_left = 0;
    gaps_on    = 1'b0;
    clear_parse_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_checks();
    test_payload_type();
    test_length_limits();
    test_random_traffic();

    wait_drain();
    if (mismatches == 0 && summaries_due.size() == 0) begin
      $display("sap_header_parser: match");
    end else begin
      $display("sap_header_parser: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sap_hdr_pkg.sv
hdl/sap_hdr_in_if.sv
hdl/sap_hdr_out_if.sv
hdl/sap_hdr_capture.sv
hdl/sap_header_parser.sv
sim/tb_top.sv
